### design/pbs_pkg.sv
// shared constants, types and helpers for the particle bounce step unit
package pbs_pkg;

  localparam int MAX_WALLS = 4;

  // configuration register indexes
  localparam logic [2:0] REG_CANVAS_W = 3'd0;
  localparam logic [2:0] REG_CANVAS_H = 3'd1;
  localparam logic [2:0] REG_WALL_CNT = 3'd2;
  localparam logic [2:0] REG_WALL_A   = 3'd3;
  localparam logic [2:0] REG_WALL_B   = 3'd4;
  localparam logic [2:0] REG_WALL_C   = 3'd5;
  localparam logic [2:0] REG_WALL_D   = 3'd6;

  localparam logic [15:0] CANVAS_W_RST = 16'd20480;
  localparam logic [15:0] CANVAS_H_RST = 16'd11520;

  // divider geometry: numerator, divisor and quotient bits
  localparam int DIV_NUM_W = 58;
  localparam int DIV_DEN_W = 34;
  localparam int DIV_QUO_W = 22;

  // item fields carried alongside the wall arithmetic
  typedef struct packed {
    logic [15:0]        px;
    logic [15:0]        py;
    logic [15:0]        nx;
    logic [15:0]        ny;
    logic signed [19:0] vx;
    logic signed [19:0] vy;
    logic               hit;
  } side_t;

  // saturate a 24 bit signed value to 20 bits
  function automatic logic signed [19:0] sat20(input logic signed [23:0] v);
    logic signed [19:0] r;
    if (v > 24'sd524287) r = 20'sd524287;
    else if (v < -24'sd524288) r = -20'sd524288;
    else r = v[19:0];
    return r;
  endfunction

  // negate with saturation
  function automatic logic signed [19:0] neg20(input logic signed [19:0] v);
    logic signed [19:0] r;
    if (v == -20'sd524288) r = 20'sd524287;
    else r = -v;
    return r;
  endfunction

  // clamp a 24 bit signed value to the position range
  function automatic logic [15:0] clamp16(input logic signed [23:0] v);
    logic [15:0] r;
    if (v < 24'sd0) r = 16'd0;
    else if (v > 24'sd65535) r = 16'hffff;
    else r = v[15:0];
    return r;
  endfunction

endpackage

### design/pbs_div.sv
// pipelined restoring divider, one quotient bit per stage, floor rounding
module pbs_div #(
  parameter int NumW = pbs_pkg::DIV_NUM_W,
  parameter int DenW = pbs_pkg::DIV_DEN_W,
  parameter int QuoW = pbs_pkg::DIV_QUO_W
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic [DenW-1:0]        den_i,
  output logic signed [QuoW:0]   quo_o
);

  localparam int CW = (NumW > DenW + QuoW) ? NumW : DenW + QuoW;

  logic [CW-1:0]   r_q [QuoW+1];
  logic [DenW-1:0] d_q [QuoW+1];
  logic [QuoW-1:0] q_q [QuoW+1];
  logic            n_q [QuoW+1];

  logic signed [NumW-1:0] num_abs;
  logic [QuoW:0]          q_up;

  // magnitude and sign at the entry
  assign num_abs = num_i[NumW-1] ? -num_i : num_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0] <= CW'($unsigned(num_abs));
      d_q[0] <= den_i;
      q_q[0] <= '0;
      n_q[0] <= num_i[NumW-1];
    end
  end

  // one trial subtraction per stage, most significant quotient bit first
  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    logic [CW-1:0] dsh;
    logic [CW-1:0] diff;
    logic          ge;
    assign dsh  = CW'(d_q[k]) << (QuoW - 1 - k);
    assign ge   = r_q[k] >= dsh;
    assign diff = r_q[k] - dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1] <= ge ? diff : r_q[k];
        d_q[k+1] <= d_q[k];
        q_q[k+1] <= q_q[k] | (ge ? (QuoW'(1) << (QuoW - 1 - k)) : '0);
        n_q[k+1] <= n_q[k];
      end
    end
  end

  // floor for negative numerators rounds the magnitude up
  assign q_up  = {1'b0, q_q[QuoW]} + (QuoW+1)'(r_q[QuoW] != '0);
  assign quo_o = n_q[QuoW] ? -$signed(q_up) : $signed({1'b0, q_q[QuoW]});

endmodule

### design/particle_bounce_step_unit.sv
// particle bounce step: move, canvas bounce, wall crossing and reflection
// pipeline: 8 arithmetic stages, 23 divider stages and an output register;
//   the four divisions run side by side
// throughput: one item per cycle; the whole pipe stalls only while the output
//   register holds a result that is not taken
// reset: asynchronous, active low; clears valid bits and walls, sets the default canvas size
module particle_bounce_step_unit #(
  parameter int MaxWalls = pbs_pkg::MAX_WALLS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        pos_x_i,
  input  logic [15:0]        pos_y_i,
  input  logic signed [19:0] vel_x_i,
  input  logic signed [19:0] vel_y_i,
  input  logic               just_hit_i,
  input  logic [15:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        new_pos_x_o,
  output logic [15:0]        new_pos_y_o,
  output logic signed [19:0] new_vel_x_o,
  output logic signed [19:0] new_vel_y_o,
  output logic               new_just_hit_o
);

  localparam int QW = pbs_pkg::DIV_QUO_W;
  localparam int NW = pbs_pkg::DIV_NUM_W;
  localparam int DW = pbs_pkg::DIV_DEN_W;

  // configuration registers
  logic [15:0] cw_q, ch_q;
  logic [2:0]  wcnt_q;
  logic [63:0] wall_q [4];

  logic en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q   <= pbs_pkg::CANVAS_W_RST;
      ch_q   <= pbs_pkg::CANVAS_H_RST;
      wcnt_q <= '0;
      for (int i = 0; i < 4; i++) wall_q[i] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pbs_pkg::REG_CANVAS_W: cw_q      <= cfg_data_i[15:0];
        pbs_pkg::REG_CANVAS_H: ch_q      <= cfg_data_i[15:0];
        pbs_pkg::REG_WALL_CNT: wcnt_q    <= cfg_data_i[2:0];
        pbs_pkg::REG_WALL_A:   wall_q[0] <= cfg_data_i;
        pbs_pkg::REG_WALL_B:   wall_q[1] <= cfg_data_i;
        pbs_pkg::REG_WALL_C:   wall_q[2] <= cfg_data_i;
        pbs_pkg::REG_WALL_D:   wall_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: the pipe moves unless the output item is held
  logic ovld_q;
  assign en         = !ovld_q || out_ready_i;
  assign in_ready_o = en;

  // stage 1: displacement products
  logic                v1_q, jh1_q;
  logic [15:0]         px1_q, py1_q;
  logic signed [19:0]  vx1_q, vy1_q;
  logic signed [36:0]  mx1_q, my1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px1_q <= pos_x_i;
      py1_q <= pos_y_i;
      vx1_q <= vel_x_i;
      vy1_q <= vel_y_i;
      jh1_q <= just_hit_i;
      mx1_q <= vel_x_i * $signed({1'b0, time_step_i});
      my1_q <= vel_y_i * $signed({1'b0, time_step_i});
    end
  end

  // stage 2: round the move, bounce off the canvas edges
  logic signed [36:0] rx, ry;
  logic signed [17:0] nxs, nys;
  logic [15:0]        nx2, ny2;
  logic signed [19:0] vx2, vy2;
  logic               outx, outy;

  always_comb begin
    rx   = mx1_q + 37'sd524288;
    ry   = my1_q + 37'sd524288;
    nxs  = $signed({2'b00, px1_q}) + 18'($signed(rx[36:20]));
    nys  = $signed({2'b00, py1_q}) + 18'($signed(ry[36:20]));
    outx = nxs[17] || (nxs > $signed({2'b00, cw_q}));
    outy = nys[17] || (nys > $signed({2'b00, ch_q}));
    nx2  = nxs[17] ? 16'd0 : (outx ? cw_q : nxs[15:0]);
    ny2  = nys[17] ? 16'd0 : (outy ? ch_q : nys[15:0]);
    vx2  = outx ? pbs_pkg::neg20(vx1_q) : vx1_q;
    vy2  = outy ? pbs_pkg::neg20(vy1_q) : vy1_q;
  end

  logic               v2_q, jh2_q;
  logic [15:0]        px2_q, py2_q, nx2_q, ny2_q;
  logic signed [19:0] vx2_q, vy2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px2_q <= px1_q;
      py2_q <= py1_q;
      nx2_q <= nx2;
      ny2_q <= ny2;
      vx2_q <= vx2;
      vy2_q <= vy2;
      jh2_q <= jh1_q;
    end
  end

  // stage 3: crossing products, one lane per wall
  logic signed [16:0] s1x, s1y;
  logic signed [33:0] pa [MaxWalls];
  logic signed [33:0] pb [MaxWalls];
  logic signed [33:0] pc [MaxWalls];
  logic signed [33:0] pd [MaxWalls];
  logic signed [33:0] pe [MaxWalls];
  logic signed [33:0] pf [MaxWalls];

  always_comb begin
    logic signed [16:0] s2x, s2y, ex, ey;
    s1x = $signed({1'b0, nx2_q}) - $signed({1'b0, px2_q});
    s1y = $signed({1'b0, ny2_q}) - $signed({1'b0, py2_q});
    for (int i = 0; i < MaxWalls; i++) begin
      s2x   = $signed({1'b0, wall_q[i][31:16]}) - $signed({1'b0, wall_q[i][63:48]});
      s2y   = $signed({1'b0, wall_q[i][15:0]}) - $signed({1'b0, wall_q[i][47:32]});
      ex    = $signed({1'b0, px2_q}) - $signed({1'b0, wall_q[i][63:48]});
      ey    = $signed({1'b0, py2_q}) - $signed({1'b0, wall_q[i][47:32]});
      pa[i] = s1x * s2y;
      pb[i] = s2x * s1y;
      pc[i] = s1x * ey;
      pd[i] = s1y * ex;
      pe[i] = s2x * ey;
      pf[i] = s2y * ex;
    end
  end

  logic               v3_q;
  pbs_pkg::side_t     sd3_q;
  logic               jh3_q;
  logic signed [16:0] s1x3_q, s1y3_q;
  logic signed [33:0] pa3_q [MaxWalls];
  logic signed [33:0] pb3_q [MaxWalls];
  logic signed [33:0] pc3_q [MaxWalls];
  logic signed [33:0] pd3_q [MaxWalls];
  logic signed [33:0] pe3_q [MaxWalls];
  logic signed [33:0] pf3_q [MaxWalls];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd3_q  <= '{px: px2_q, py: py2_q, nx: nx2_q, ny: ny2_q, vx: vx2_q, vy: vy2_q,
                  hit: 1'b0};
      jh3_q  <= jh2_q;
      s1x3_q <= s1x;
      s1y3_q <= s1y;
      for (int i = 0; i < MaxWalls; i++) begin
        pa3_q[i] <= pa[i];
        pb3_q[i] <= pb[i];
        pc3_q[i] <= pc[i];
        pd3_q[i] <= pd[i];
        pe3_q[i] <= pe[i];
        pf3_q[i] <= pf[i];
      end
    end
  end

  // stage 4: denominator and both segment parameters
  logic               v4_q, jh4_q;
  pbs_pkg::side_t     sd4_q;
  logic signed [16:0] s1x4_q, s1y4_q;
  logic signed [34:0] den4_q [MaxWalls];
  logic signed [34:0] sn4_q  [MaxWalls];
  logic signed [34:0] tn4_q  [MaxWalls];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd4_q  <= sd3_q;
      jh4_q  <= jh3_q;
      s1x4_q <= s1x3_q;
      s1y4_q <= s1y3_q;
      for (int i = 0; i < MaxWalls; i++) begin
        den4_q[i] <= pa3_q[i] - pb3_q[i];
        sn4_q[i]  <= pc3_q[i] - pd3_q[i];
        tn4_q[i]  <= pe3_q[i] - pf3_q[i];
      end
    end
  end

  // stage 5: crossing test per wall, first wall in order wins
  logic [MaxWalls-1:0] sel5;
  logic                hit5;
  logic signed [16:0]  s2x5, s2y5;
  logic [32:0]         dsel5, tsel5;

  always_comb begin
    logic signed [34:0] da, sf, tf;
    logic               ng, ok;
    sel5  = '0;
    hit5  = 1'b0;
    s2x5  = '0;
    s2y5  = '0;
    dsel5 = '0;
    tsel5 = '0;
    for (int i = 0; i < MaxWalls; i++) begin
      ng = den4_q[i][34];
      da = ng ? -den4_q[i] : den4_q[i];
      sf = ng ? -sn4_q[i] : sn4_q[i];
      tf = ng ? -tn4_q[i] : tn4_q[i];
      ok = (den4_q[i] != '0) && !sf[34] && (sf <= da) && !tf[34] && (tf <= da) &&
           (3'(i) < wcnt_q) && !jh4_q;
      if (ok && !hit5) begin
        hit5    = 1'b1;
        sel5[i] = 1'b1;
        s2x5    = $signed({1'b0, wall_q[i][31:16]}) - $signed({1'b0, wall_q[i][63:48]});
        s2y5    = $signed({1'b0, wall_q[i][15:0]}) - $signed({1'b0, wall_q[i][47:32]});
        dsel5   = da[32:0];
        tsel5   = tf[32:0];
      end
    end
  end

  logic               v5_q;
  pbs_pkg::side_t     sd5_q;
  logic signed [16:0] s1x5_q, s1y5_q, s2x5_q, s2y5_q;
  logic [32:0]        den5_q, tn5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd5_q     <= '{px: sd4_q.px, py: sd4_q.py, nx: sd4_q.nx, ny: sd4_q.ny,
                     vx: sd4_q.vx, vy: sd4_q.vy, hit: hit5};
      s1x5_q    <= s1x4_q;
      s1y5_q    <= s1y4_q;
      s2x5_q    <= s2x5;
      s2y5_q    <= s2y5;
      den5_q    <= dsel5;
      tn5_q     <= tsel5;
    end
  end

  // stage 6: normal products and split crossing products
  logic signed [16:0] nrx5, nry5;
  assign nrx5 = -s2y5_q;
  assign nry5 = s2x5_q;

  logic               v6_q;
  pbs_pkg::side_t     sd6_q;
  logic signed [16:0] nrx6_q, nry6_q;
  logic [32:0]        den6_q;
  logic signed [33:0] sqx6_q, sqy6_q;
  logic signed [36:0] pvx6_q, pvy6_q;
  logic signed [34:0] tlx6_q, tly6_q;
  logic signed [33:0] thx6_q, thy6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd6_q  <= sd5_q;
      nrx6_q <= nrx5;
      nry6_q <= nry5;
      den6_q <= den5_q;
      sqx6_q <= s2x5_q * s2x5_q;
      sqy6_q <= s2y5_q * s2y5_q;
      pvx6_q <= sd5_q.vx * nrx5;
      pvy6_q <= sd5_q.vy * nry5;
      tlx6_q <= s1x5_q * $signed({1'b0, tn5_q[16:0]});
      tly6_q <= s1y5_q * $signed({1'b0, tn5_q[16:0]});
      thx6_q <= s1x5_q * $signed({1'b0, tn5_q[32:17]});
      thy6_q <= s1y5_q * $signed({1'b0, tn5_q[32:17]});
    end
  end

  // stage 7: length squared, dot product, crossing offsets
  logic signed [34:0] len2_7;
  assign len2_7 = sqx6_q + sqy6_q;

  logic               v7_q;
  pbs_pkg::side_t     sd7_q;
  logic signed [16:0] nrx7_q, nry7_q;
  logic [32:0]        den7_q, len7_q;
  logic signed [37:0] dot7_q;
  logic signed [51:0] mx7_q, my7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (en) v7_q <= v6_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd7_q  <= sd6_q;
      nrx7_q <= nrx6_q;
      nry7_q <= nry6_q;
      den7_q <= den6_q;
      len7_q <= len2_7[32:0];
      dot7_q <= pvx6_q + pvy6_q;
      mx7_q  <= (52'(thx6_q) <<< 17) + 52'(tlx6_q);
      my7_q  <= (52'(thy6_q) <<< 17) + 52'(tly6_q);
    end
  end

  // stage 8: dot product times normal, cut in two halves
  logic signed [19:0] dlo7;
  logic signed [18:0] dhi7;
  assign dlo7 = $signed({1'b0, dot7_q[18:0]});
  assign dhi7 = dot7_q[37:19];

  logic               v8_q;
  pbs_pkg::side_t     sd8_q;
  logic [32:0]        den8_q, len8_q;
  logic signed [51:0] mx8_q, my8_q;
  logic signed [36:0] rxl8_q, ryl8_q;
  logic signed [35:0] rxh8_q, ryh8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else if (en) v8_q <= v7_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd8_q  <= sd7_q;
      den8_q <= den7_q;
      len8_q <= len7_q;
      mx8_q  <= mx7_q;
      my8_q  <= my7_q;
      rxl8_q <= dlo7 * nrx7_q;
      ryl8_q <= dlo7 * nry7_q;
      rxh8_q <= dhi7 * nrx7_q;
      ryh8_q <= dhi7 * nry7_q;
    end
  end

  // divider operands: round to nearest via floor((2n + d) / 2d)
  logic signed [NW-1:0] num_rx, num_ry, num_px, num_py;
  logic [DW-1:0]        dv_len, dv_den;

  always_comb begin
    logic signed [NW-1:0] rnx, rny;
    rnx    = (NW'(rxh8_q) <<< 19) + NW'(rxl8_q);
    rny    = (NW'(ryh8_q) <<< 19) + NW'(ryl8_q);
    num_rx = (rnx <<< 2) + $signed(NW'(len8_q));
    num_ry = (rny <<< 2) + $signed(NW'(len8_q));
    num_px = (NW'(mx8_q) <<< 1) + $signed(NW'(den8_q));
    num_py = (NW'(my8_q) <<< 1) + $signed(NW'(den8_q));
    dv_len = {len8_q, 1'b0};
    dv_den = {den8_q, 1'b0};
  end

  logic signed [QW:0] q_rx, q_ry, q_px, q_py;

  pbs_div #(.NumW(NW), .DenW(DW), .QuoW(QW)) u_div_rx (
    .clk_i(clk_i), .en_i(en), .num_i(num_rx), .den_i(dv_len), .quo_o(q_rx));
  pbs_div #(.NumW(NW), .DenW(DW), .QuoW(QW)) u_div_ry (
    .clk_i(clk_i), .en_i(en), .num_i(num_ry), .den_i(dv_len), .quo_o(q_ry));
  pbs_div #(.NumW(NW), .DenW(DW), .QuoW(QW)) u_div_px (
    .clk_i(clk_i), .en_i(en), .num_i(num_px), .den_i(dv_den), .quo_o(q_px));
  pbs_div #(.NumW(NW), .DenW(DW), .QuoW(QW)) u_div_py (
    .clk_i(clk_i), .en_i(en), .num_i(num_py), .den_i(dv_den), .quo_o(q_py));

  // item fields and valid bits travel beside the divider stages
  pbs_pkg::side_t sdd_q [QW+1];
  logic [QW:0]    vdd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vdd_q <= '0;
    else if (en) vdd_q <= {vdd_q[QW-1:0], v8_q};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sdd_q[0] <= sd8_q;
      for (int k = 1; k <= QW; k++) sdd_q[k] <= sdd_q[k-1];
    end
  end

  // output stage: reflected velocity and crossing point on a hit
  pbs_pkg::side_t     sdo;
  logic signed [19:0] rvx, rvy;
  logic [15:0]        cpx, cpy;

  always_comb begin
    sdo = sdd_q[QW];
    rvx = pbs_pkg::sat20(24'(sdo.vx) - 24'(q_rx));
    rvy = pbs_pkg::sat20(24'(sdo.vy) - 24'(q_ry));
    cpx = pbs_pkg::clamp16($signed({8'd0, sdo.px}) + 24'(q_px));
    cpy = pbs_pkg::clamp16($signed({8'd0, sdo.py}) + 24'(q_py));
  end

  logic [15:0]        opx_q, opy_q;
  logic signed [19:0] ovx_q, ovy_q;
  logic               ohit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovld_q <= 1'b0;
    else if (en) ovld_q <= vdd_q[QW];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      opx_q  <= sdo.hit ? cpx : sdo.nx;
      opy_q  <= sdo.hit ? cpy : sdo.ny;
      ovx_q  <= sdo.hit ? rvx : sdo.vx;
      ovy_q  <= sdo.hit ? rvy : sdo.vy;
      ohit_q <= sdo.hit;
    end
  end

  assign out_valid_o    = ovld_q;
  assign new_pos_x_o    = opx_q;
  assign new_pos_y_o    = opy_q;
  assign new_vel_x_o    = ovx_q;
  assign new_vel_y_o    = ovy_q;
  assign new_just_hit_o = ohit_q;

  // at most one wall wins an item
  a_one_winner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(sel5))
    else $error("more than one wall selected");

  // a wall hit needs at least one wall in use
  a_hit_needs_wall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && new_just_hit_o |-> wcnt_q != 3'd0)
    else $error("wall hit with no wall in use");

  // a stalled pipe keeps its valid bits
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vdd_q) && $stable(v5_q) && $stable(v1_q))
    else $error("valid bits moved during a stall");

endmodule

### test/tb_particle_bounce_step_unit.sv
// self-checking testbench for the particle bounce step unit
`timescale 1ns / 100ps

module tb_particle_bounce_step_unit;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int         DRAIN_CYCLES = 40;
  localparam longint     CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [15:0]        px;
    logic [15:0]        py;
    logic signed [19:0] vx;
    logic signed [19:0] vy;
    logic               jh;
    logic [15:0]        dt;
  } particle_t;

  typedef struct packed {
    logic [15:0]        px;
    logic [15:0]        py;
    logic signed [19:0] vx;
    logic signed [19:0] vy;
    logic               hit;
  } motion_t;

  typedef struct packed {
    logic [3:0] grp;
    particle_t  p;
    logic       known;
    motion_t    r;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [63:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [15:0]        pos_x_i = '0;
  logic [15:0]        pos_y_i = '0;
  logic signed [19:0] vel_x_i = '0;
  logic signed [19:0] vel_y_i = '0;
  logic               just_hit_i = 1'b0;
  logic [15:0]        time_step_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [15:0]        new_pos_x_o;
  logic [15:0]        new_pos_y_o;
  logic signed [19:0] new_vel_x_o;
  logic signed [19:0] new_vel_y_o;
  logic               new_just_hit_o;

  // local copy of the configuration
  logic [15:0] canvas_w;
  logic [15:0] canvas_h;
  logic [2:0]  wall_cnt;
  logic [63:0] walls [4];

  motion_t pending_motion [$];
  int      mismatches = 0;
  int      results_seen = 0;
  bit      calm = 1'b0;
  longint  cycles = 0;
  row_t    rows [$];

  particle_bounce_step_unit DUT (.*);

  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic longint round_div(longint n, longint d);
    return floor_div(2 * n + d, 2 * d);
  endfunction

  function automatic longint sat_vel(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // next position and velocity of one particle
  function automatic motion_t bounce_predict(particle_t p);
    longint px, py, vx, vy, nx, ny, cw, ch;
    longint q1x, q1y, q2x, q2y, s1x, s1y, s2x, s2y, den, sn, tn;
    longint nrx, nry, len2, dotv, rvx, rvy;
    int n;
    bit hit;
    motion_t r;
    px = p.px; py = p.py; vx = p.vx; vy = p.vy;
    cw = canvas_w; ch = canvas_h;
    hit = 1'b0;
    nx = px + round_div(vx * longint'(p.dt), longint'(1) << 20);
    ny = py + round_div(vy * longint'(p.dt), longint'(1) << 20);
    if (nx < 0 || nx > cw) begin
      vx = sat_vel(-vx);
      nx = clip(nx, 0, cw);
    end
    if (ny < 0 || ny > ch) begin
      vy = sat_vel(-vy);
      ny = clip(ny, 0, ch);
    end
    if (!p.jh) begin
      n = (wall_cnt > pbs_pkg::MAX_WALLS) ? pbs_pkg::MAX_WALLS : wall_cnt;
      for (int i = 0; i < n && !hit; i++) begin
        q1x = walls[i][63:48]; q1y = walls[i][47:32];
        q2x = walls[i][31:16]; q2y = walls[i][15:0];
        s1x = nx - px; s1y = ny - py;
        s2x = q2x - q1x; s2y = q2y - q1y;
        den = s1x * s2y - s2x * s1y;
        sn = s1x * (py - q1y) - s1y * (px - q1x);
        tn = s2x * (py - q1y) - s2y * (px - q1x);
        if (den == 0) continue;
        if (den < 0) begin
          den = -den; sn = -sn; tn = -tn;
        end
        if (sn < 0 || sn > den || tn < 0 || tn > den) continue;
        // reflect about the wall normal, land on the crossing point
        nrx = -s2y;
        nry = s2x;
        len2 = nrx * nrx + nry * nry;
        dotv = vx * nrx + vy * nry;
        rvx = sat_vel(vx - round_div(2 * dotv * nrx, len2));
        rvy = sat_vel(vy - round_div(2 * dotv * nry, len2));
        vx = rvx;
        vy = rvy;
        nx = px + round_div(s1x * tn, den);
        ny = py + round_div(s1y * tn, den);
        hit = 1'b1;
      end
    end
    r.px = 16'(clip(nx, 0, 65535));
    r.py = 16'(clip(ny, 0, 65535));
    r.vx = vx[19:0];
    r.vy = vy[19:0];
    r.hit = hit;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      pbs_pkg::REG_CANVAS_W: canvas_w = val[15:0];
      pbs_pkg::REG_CANVAS_H: canvas_h = val[15:0];
      pbs_pkg::REG_WALL_CNT: wall_cnt = val[2:0];
      pbs_pkg::REG_WALL_A:   walls[0] = val;
      pbs_pkg::REG_WALL_B:   walls[1] = val;
      pbs_pkg::REG_WALL_C:   walls[2] = val;
      pbs_pkg::REG_WALL_D:   walls[3] = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_motion.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_scene(logic [15:0] cw, logic [15:0] ch, logic [2:0] cnt,
                           logic [63:0] wa, logic [63:0] wb,
                           logic [63:0] wc, logic [63:0] wd);
    wait_idle();
    write_reg(pbs_pkg::REG_CANVAS_W, {48'd0, cw});
    write_reg(pbs_pkg::REG_CANVAS_H, {48'd0, ch});
    write_reg(pbs_pkg::REG_WALL_CNT, {61'd0, cnt});
    write_reg(pbs_pkg::REG_WALL_A, wa);
    write_reg(pbs_pkg::REG_WALL_B, wb);
    write_reg(pbs_pkg::REG_WALL_C, wc);
    write_reg(pbs_pkg::REG_WALL_D, wd);
  endtask

  // offer one item, with an optional idle gap first
  task automatic send_particle(particle_t p, logic known, motion_t r);
    if (!calm && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pos_x_i     <= p.px;
    pos_y_i     <= p.py;
    vel_x_i     <= p.vx;
    vel_y_i     <= p.vy;
    just_hit_i  <= p.jh;
    time_step_i <= p.dt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_motion.push_back(known ? r : bounce_predict(p));
  endtask

  function automatic logic [63:0] rand_wall(logic [15:0] cw, logic [15:0] ch);
    return {16'($urandom_range(cw)), 16'($urandom_range(ch)),
            16'($urandom_range(cw)), 16'($urandom_range(ch))};
  endfunction

  function automatic particle_t rand_particle(logic [15:0] cw, logic [15:0] ch);
    logic [95:0] raw;
    particle_t p;
    raw = {$urandom, $urandom, $urandom};
    p = raw[$bits(particle_t)-1:0];
    if ($urandom_range(99) < 75) begin
      // in-canvas particle with a long move so that walls get crossed
      p.px = 16'($urandom_range(cw));
      p.py = 16'($urandom_range(ch));
      p.vx = $signed(20'($urandom_range(0, 262143))) - 20'sd131072;
      p.vy = $signed(20'($urandom_range(0, 262143))) - 20'sd131072;
      p.jh = ($urandom_range(99) < 20);
    end
    return p;
  endfunction

  // receiver: random idling, one long hold-off, and result checking
  initial begin
    motion_t e;
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_motion.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
        end else begin
          e = pending_motion.pop_front();
          if (new_pos_x_o !== e.px || new_pos_y_o !== e.py || new_vel_x_o !== e.vx ||
              new_vel_y_o !== e.vy || new_just_hit_o !== e.hit) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                       e.px, e.py, e.vx, e.vy, e.hit, new_pos_x_o, new_pos_y_o,
                       new_vel_x_o, new_vel_y_o, new_just_hit_o);
          end
        end
        if (results_seen == 600) hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 33);
      end
    end
  end

  // stimulus
  initial begin
    logic [15:0] cw, ch;
    canvas_w = pbs_pkg::CANVAS_W_RST;
    canvas_h = pbs_pkg::CANVAS_H_RST;
    wall_cnt = '0;
    for (int i = 0; i < 4; i++) walls[i] = '0;

    // directed table: reset canvas, walls, zero canvas, full canvas
    rows.push_back({4'd0, {16'd0, 16'd0, 20'sd0, 20'sd0, 1'b0, 16'd0},
                    1'b1, {16'd0, 16'd0, 20'sd0, 20'sd0, 1'b0}});
    rows.push_back({4'd0, {16'hffff, 16'hffff, 20'sd0, 20'sd0, 1'b0, 16'hffff},
                    1'b1, {pbs_pkg::CANVAS_W_RST, pbs_pkg::CANVAS_H_RST, 20'sd0, 20'sd0,
                           1'b0}});
    rows.push_back({4'd0, {16'd0, 16'd0, -20'sd524288, -20'sd524288, 1'b0, 16'hffff},
                    1'b1, {16'd0, 16'd0, 20'sd524287, 20'sd524287, 1'b0}});
    rows.push_back({4'd0, {16'd0, 16'd0, 20'sd524287, 20'sd524287, 1'b1, 16'hffff},
                    1'b1, {pbs_pkg::CANVAS_W_RST, pbs_pkg::CANVAS_H_RST, -20'sd524287,
                           -20'sd524287, 1'b0}});
    rows.push_back({4'd1, {16'd1000, 16'd5000, 20'sd25600, 20'sd0, 1'b0, 16'd32768},
                    1'b0, 73'd0});
    rows.push_back({4'd1, {16'd1000, 16'd5000, 20'sd25600, 20'sd0, 1'b1, 16'd32768},
                    1'b0, 73'd0});
    rows.push_back({4'd1, {16'd5000, 16'd7800, 20'sd0, 20'sd25600, 1'b0, 16'd32768},
                    1'b0, 73'd0});
    rows.push_back({4'd1, {16'd1000, 16'd7900, 20'sd25600, 20'sd25600, 1'b0, 16'd32768},
                    1'b0, 73'd0});
    rows.push_back({4'd1, {16'd3000, 16'd8000, 20'sd25600, 20'sd0, 1'b0, 16'd32768},
                    1'b0, 73'd0});
    rows.push_back({4'd1, {16'd3000, 16'd3000, 20'sd25600, 20'sd9000, 1'b0, 16'd0},
                    1'b0, 73'd0});
    rows.push_back({4'd1, {16'd1000, 16'd2000, 20'sd25600, 20'sd0, 1'b0, 16'd24576},
                    1'b0, 73'd0});
    rows.push_back({4'd1, {16'd2000, 16'd2000, -20'sd25600, -20'sd12800, 1'b0, 16'd65535},
                    1'b0, 73'd0});
    rows.push_back({4'd2, {16'd0, 16'd0, 20'sd0, 20'sd0, 1'b0, 16'd100},
                    1'b1, {16'd0, 16'd0, 20'sd0, 20'sd0, 1'b0}});
    rows.push_back({4'd2, {16'd5, 16'd0, 20'sd100, 20'sd0, 1'b0, 16'd0},
                    1'b1, {16'd0, 16'd0, -20'sd100, 20'sd0, 1'b0}});
    rows.push_back({4'd3, {16'd0, 16'd0, 20'sd524287, 20'sd524287, 1'b0, 16'hffff},
                    1'b0, 73'd0});
    rows.push_back({4'd3, {16'hffff, 16'd0, -20'sd524288, 20'sd524287, 1'b0, 16'hffff},
                    1'b0, 73'd0});
    rows.push_back({4'd3, {16'hffff, 16'hffff, -20'sd524288, -20'sd524288, 1'b0, 16'hffff},
                    1'b0, 73'd0});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int i = 0; i < rows.size(); i++) begin
      if (i > 0 && rows[i].grp != rows[i-1].grp) begin
        case (rows[i].grp)
          4'd1: set_scene(16'd20480, 16'd11520, 3'd7,
                          {16'd1600, 16'd0, 16'd1600, 16'd11520},
                          {16'd3000, 16'd3000, 16'd3000, 16'd3000},
                          {16'd0, 16'd8000, 16'd20480, 16'd8000},
                          {16'd0, 16'd0, 16'd20480, 16'd11520});
          4'd2: set_scene(16'd0, 16'd0, 3'd0, '0, '0, '0, '0);
          default: set_scene(16'hffff, 16'hffff, 3'd4,
                             {16'hffff, 16'd0, 16'd0, 16'hffff},
                             {16'd0, 16'd0, 16'hffff, 16'hffff},
                             {16'd32768, 16'd0, 16'd32768, 16'hffff},
                             {16'd0, 16'd32768, 16'hffff, 16'd32768});
        endcase
      end
      send_particle(rows[i].p, rows[i].known, rows[i].r);
    end

    // random phases over several canvas and wall settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin cw = 16'hffff; ch = 16'hffff; end
        4: begin cw = 16'd0; ch = 16'd0; end
        default: begin
          cw = 16'($urandom_range(1000, 40000));
          ch = 16'($urandom_range(1000, 40000));
        end
      endcase
      set_scene(cw, ch, (ph == 1) ? 3'd4 : 3'($urandom_range(0, 7)),
                rand_wall(cw, ch), rand_wall(cw, ch), rand_wall(cw, ch),
                (ph == 3) ? 64'($urandom) << 32 | 64'($urandom) : rand_wall(cw, ch));
      if (ph == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
      calm = (ph == 2);
      for (int k = 0; k < 200; k++) send_particle(rand_particle(cw, ch), 1'b0, 73'd0);
      calm = 1'b0;
    end

    wait_idle();
    if (mismatches == 0 && pending_motion.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/pbs_pkg.sv
design/pbs_div.sv
design/particle_bounce_step_unit.sv
test/tb_particle_bounce_step_unit.sv
